FILE: design/ipt_pkg.sv
package ipt_pkg;

    localparam int FRAME_COUNT_DEF = 64;
    localparam int OFFSET_BITS_DEF = 8;

    localparam int ADDR_W = 16;
    localparam int PAGE_W = 8;
    localparam int PA_W   = 14;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [PAGE_W-1:0] t_page;
    typedef logic [PA_W-1:0]   t_paddr;
    typedef logic [CNT_W-1:0]  t_count;

    // broadcast from the sequencer to every table cell
    typedef struct packed {
        logic  update;   // lookup missed: victim cell takes the page, token moves on
        t_page page;     // page under lookup
    } t_cell_cmd;

endpackage

FILE: design/ipt_cell.sv
module ipt_cell #(
    parameter logic TOKEN_AT_RESET = 1'b0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ipt_pkg::t_cell_cmd i_cmd,
    input  logic              i_token,
    output logic              o_token,
    output logic              o_match
);
    import ipt_pkg::*;

    logic  r_valid;
    t_page r_tag;
    logic  r_token;

    assign o_match = r_valid && (r_tag == i_cmd.page);
    assign o_token = r_token;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_token <= TOKEN_AT_RESET;
        end else if (i_cmd.update) begin
            if (r_token) begin
                r_valid <= 1'b1;
            end
            // pass the victim token one cell along the ring
            r_token <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && r_token) begin
            r_tag <= i_cmd.page;
        end
    end

endmodule

FILE: design/ipt_encoder.sv
module ipt_encoder #(
    parameter int FRAME_COUNT = ipt_pkg::FRAME_COUNT_DEF
) (
    input  logic [FRAME_COUNT-1:0]         i_vec,
    output logic                           o_any,
    output logic [$clog2(FRAME_COUNT)-1:0] o_index
);
    import ipt_pkg::*;

    localparam int FRAME_BITS = $clog2(FRAME_COUNT);

    // at most one bit is set, so OR-ing the indexes of set bits encodes it
    always_comb begin
        o_index = '0;
        for (int i = 0; i < FRAME_COUNT; i++) begin
            if (i_vec[i]) begin
                o_index = o_index | FRAME_BITS'(i);
            end
        end
    end

    assign o_any = |i_vec;

endmodule

FILE: design/inverted_page_table_fifo_unit.sv
// Inverted page table with FIFO frame replacement.
// o_done is registered: the accepting edge moves the sequencer into lookup, and the
// lookup state then sets the done register, which drives o_done.
// A new item is accepted only while idle; busy is high during the lookup.
// Reset (i_rst_n low, synchronous): every table entry invalid, victim at frame 0,
// both counters zero. Results are shown for one cycle; the receiver cannot stall.
module inverted_page_table_fifo_unit #(
    parameter int FRAME_COUNT = ipt_pkg::FRAME_COUNT_DEF,
    parameter int OFFSET_BITS = ipt_pkg::OFFSET_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  ipt_pkg::t_addr  i_logical_address,
    output logic            o_done,
    output ipt_pkg::t_paddr o_phys_addr,
    output logic            o_page_fault,
    output ipt_pkg::t_count o_reference_count,
    output ipt_pkg::t_count o_fault_count
);
    import ipt_pkg::*;

    localparam int FRAME_BITS = $clog2(FRAME_COUNT);

    // lookup sequencer: idle -> lookup -> idle
    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } t_state;

    t_state r_state, n_state;

    // captured item
    t_page                  r_page;
    logic [OFFSET_BITS-1:0] r_offset;

    // running counts
    t_count r_ref_cnt, n_ref_cnt;
    t_count r_flt_cnt, n_flt_cnt;

    // result registers
    logic   r_done;
    t_paddr r_paddr, n_paddr;
    logic   r_fault;

    // cell row
    t_cell_cmd               cell_cmd;
    logic [FRAME_COUNT-1:0]  match_vec;
    logic [FRAME_COUNT-1:0]  token_vec;
    logic                    hit;
    logic [FRAME_BITS-1:0]   hit_frame;
    logic [FRAME_BITS-1:0]   victim_frame;
    logic                    victim_any;
    logic [FRAME_BITS-1:0]   frame;
    logic                    accept;
    logic                    lookup;
    logic [31:0]             paddr_wide;

    assign accept = start && (r_state == S_IDLE);
    assign lookup = (r_state == S_LOOKUP);
    assign busy   = (r_state != S_IDLE);

    // the page is the byte above the offset; a 16-bit offset leaves page zero
    t_page n_page;
    assign n_page = PAGE_W'({{PAGE_W{1'b0}}, i_logical_address} >> OFFSET_BITS);

    // broadcast the page; on a miss the token holder takes it
    assign cell_cmd.page   = r_page;
    assign cell_cmd.update = lookup && !hit;

    // ring of table cells, one per frame; the victim token rides the ring
    for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
        ipt_cell #(
            .TOKEN_AT_RESET((g == 0) ? 1'b1 : 1'b0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cell_cmd),
            .i_token (token_vec[(g + FRAME_COUNT - 1) % FRAME_COUNT]),
            .o_token (token_vec[g]),
            .o_match (match_vec[g])
        );
    end

    // resident pages are unique, so at most one cell matches
    ipt_encoder #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_hit_enc (
        .i_vec   (match_vec),
        .o_any   (hit),
        .o_index (hit_frame)
    );

    ipt_encoder #(
        .FRAME_COUNT(FRAME_COUNT)
    ) u_victim_enc (
        .i_vec   (token_vec),
        .o_any   (victim_any),
        .o_index (victim_frame)
    );

    assign frame = hit ? hit_frame : victim_frame;

    // frame above offset, truncated to the physical address width
    assign paddr_wide = (32'(frame) << OFFSET_BITS) | 32'(r_offset);
    assign n_paddr    = paddr_wide[PA_W-1:0];

    always_comb begin
        n_ref_cnt = r_ref_cnt;
        n_flt_cnt = r_flt_cnt;
        if (lookup) begin
            // hold at all ones once saturated
            if (r_ref_cnt != CNT_MAX) begin
                n_ref_cnt = r_ref_cnt + 1'b1;
            end
            if (!hit && (r_flt_cnt != CNT_MAX)) begin
                n_flt_cnt = r_flt_cnt + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ref_cnt <= '0;
            r_flt_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ref_cnt <= n_ref_cnt;
            r_flt_cnt <= n_flt_cnt;
            r_done    <= lookup;
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page   <= n_page;
            r_offset <= i_logical_address[OFFSET_BITS-1:0];
        end
        if (lookup) begin
            r_paddr <= n_paddr;
            r_fault <= !hit;
        end
    end

    assign o_done             = r_done;
    assign o_phys_addr        = r_paddr;
    assign o_page_fault       = r_fault;
    assign o_reference_count  = r_ref_cnt;
    assign o_fault_count      = r_flt_cnt;

    // exactly one cell holds the victim token
    a_token_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        victim_any && $onehot(token_vec))
        else $error("victim token lost or duplicated");

    // no page is resident in two frames
    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("page resident in more than one frame");

    // an accepted item yields its result once the lookup state and the done register have passed
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##1 o_done)
        else $error("result not delivered on time");

    // faults never outrun references
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_fault_count <= o_reference_count))
        else $error("fault count exceeds reference count");

    // a miss advances the token to the next cell
    a_token_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_cmd.update && !token_vec[FRAME_COUNT-1]) |=>
            (victim_frame == $past(victim_frame) + 1'b1))
        else $error("victim pointer did not advance");

endmodule
